// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL modules.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, off while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cacc_pkg.sv =====
// Types and constants for the clock / alarm / countdown controller.
// No dependencies.
package cacc_pkg;

    typedef enum logic [1:0] {
        MODE_TOD   = 2'd0,
        MODE_CNTDN = 2'd1,
        MODE_ALM   = 2'd2,
        MODE_CAL   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_MODE   = 3'd1,
        REQ_SET    = 3'd2,
        REQ_START  = 3'd3,
        REQ_TOGGLE = 3'd4,
        REQ_POT    = 3'd5
    } req_t;

    localparam logic [4:0] TOD_HOURS_RESET = 5'd12;
    localparam logic [4:0] HOUR_MAX        = 5'd23;
    localparam logic [5:0] MINSEC_MAX      = 6'd59;
    localparam logic [3:0] RING_RESET      = 4'd5;

endpackage

// ===== rtl/clock_alarm_countdown_controller_core.sv =====
// Clock / alarm / countdown controller core; depends on cacc_pkg and assert_macros.svh.
// An accepted input item is held in the input register, then passes to the result register;
// the event logic is one pass between the two registers.
// One item per cycle while results are taken; a result not yet taken stalls the input stage.
// Reset (rst_n low, async): time 12:00:00, clock mode, alarm 00:00 armed, countdown 00:00
// stopped, buzzer off, ring length 5, both stages empty.
`include "assert_macros.svh"

module clock_alarm_countdown_controller_core
    import cacc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] req_type,
    input  logic [7:0] pot_value,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] mode,
    output logic [4:0] clock_hours,
    output logic [5:0] clock_minutes,
    output logic [5:0] clock_seconds,
    output logic [5:0] countdown_minutes,
    output logic [5:0] countdown_seconds,
    output logic       countdown_running,
    output logic       alarm_enabled,
    output logic [4:0] alarm_hours,
    output logic [5:0] alarm_minutes,
    output logic       buzzer_on,
    output logic [3:0] countdown_digit
);

    // input stage
    logic       in_valid_reg;
    req_t       req_reg;
    logic [7:0] pot_reg;

    // result stage and event state
    logic       out_valid_reg;
    logic [3:0] ring_len_reg;
    mode_t      mode_reg,      mode_next;
    logic [4:0] tod_hour_reg,  tod_hour_next;
    logic [5:0] tod_min_reg,   tod_min_next;
    logic [5:0] tod_sec_reg,   tod_sec_next;
    logic [4:0] al_hour_reg,   al_hour_next;
    logic [5:0] al_min_reg,    al_min_next;
    logic       al_armed_reg,  al_armed_next;
    logic [5:0] cd_min_reg,    cd_min_next;
    logic [5:0] cd_sec_reg,    cd_sec_next;
    logic       cd_run_reg,    cd_run_next;
    logic [3:0] ring_reg,      ring_next;
    logic       buzzer_reg,    buzzer_next;
    logic [3:0] digit_reg,     digit_next;

    logic        adv;
    logic        sec_wrap;
    logic        min_wrap;
    logic [5:0]  tick_sec;
    logic [5:0]  tick_min;
    logic [4:0]  tick_hour;
    logic        alarm_hit;
    logic        cd_fire;
    logic [3:0]  ring_base;
    logic [3:0]  ring_tick;
    logic        cd_nonzero;
    logic [12:0] pot_x23;
    logic [12:0] pot_sum;

    // assertion helpers
    logic        tod_ok;
    logic        alarm_ok;
    logic        digit_ok;
    logic [17:0] held_state;

    assign adv       = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    // Time-of-day increment.
    assign sec_wrap  = (tod_sec_reg == MINSEC_MAX);
    assign min_wrap  = sec_wrap && (tod_min_reg == MINSEC_MAX);
    assign tick_sec  = sec_wrap ? 6'd0 : tod_sec_reg + 6'd1;
    assign tick_min  = !sec_wrap ? tod_min_reg :
                       ((tod_min_reg == MINSEC_MAX) ? 6'd0 : tod_min_reg + 6'd1);
    assign tick_hour = !min_wrap ? tod_hour_reg :
                       ((tod_hour_reg == HOUR_MAX) ? 5'd0 : tod_hour_reg + 5'd1);

    assign alarm_hit = al_armed_reg && (tick_hour == al_hour_reg) &&
                       (tick_min == al_min_reg) && (tick_sec == 6'd0);
    assign cd_fire   = cd_run_reg && (cd_min_reg == 6'd0) && (cd_sec_reg == 6'd0);

    // Load and decrement land on the same tick.
    assign ring_base = (alarm_hit || cd_fire) ? ring_len_reg : ring_reg;
    assign ring_tick = (ring_base != 4'd0) ? ring_base - 4'd1 : 4'd0;

    assign cd_nonzero = (cd_min_reg != 6'd0) || (cd_sec_reg != 6'd0);

    // pot * 23 / 255: shift-add multiply, then reciprocal form of /255 (exact for every 8-bit pot value).
    assign pot_x23 = {1'b0, pot_reg, 4'd0} + {3'd0, pot_reg, 2'd0}
                   + {4'd0, pot_reg, 1'b0} + {5'd0, pot_reg};
    assign pot_sum = pot_x23 + 13'd1 + {8'd0, pot_x23[12:8]};

    always_comb
    begin
        mode_next     = mode_reg;
        tod_hour_next = tod_hour_reg;
        tod_min_next  = tod_min_reg;
        tod_sec_next  = tod_sec_reg;
        al_hour_next  = al_hour_reg;
        al_min_next   = al_min_reg;
        al_armed_next = al_armed_reg;
        cd_min_next   = cd_min_reg;
        cd_sec_next   = cd_sec_reg;
        cd_run_next   = cd_run_reg;
        ring_next     = ring_reg;

        case (req_reg)
            REQ_TICK:
            begin
                tod_hour_next = tick_hour;
                tod_min_next  = tick_min;
                tod_sec_next  = tick_sec;
                ring_next     = ring_tick;
                if (cd_run_reg)
                begin
                    if (cd_sec_reg != 6'd0)
                    begin
                        cd_sec_next = cd_sec_reg - 6'd1;
                    end
                    else if (cd_min_reg != 6'd0)
                    begin
                        cd_min_next = cd_min_reg - 6'd1;
                        cd_sec_next = MINSEC_MAX;
                    end
                    else
                    begin
                        cd_run_next = 1'b0;
                    end
                end
            end
            REQ_MODE:
            begin
                mode_next = mode_t'(mode_reg + 2'd1);
            end
            REQ_SET:
            begin
                if (mode_reg == MODE_CNTDN)
                begin
                    if (!cd_run_reg)
                    begin
                        cd_min_next = (cd_min_reg == MINSEC_MAX) ? 6'd0 : cd_min_reg + 6'd1;
                        cd_sec_next = 6'd0;
                    end
                end
                else if (mode_reg == MODE_ALM)
                begin
                    al_min_next = (al_min_reg == MINSEC_MAX) ? 6'd0 : al_min_reg + 6'd1;
                end
            end
            REQ_START:
            begin
                if (mode_reg == MODE_CNTDN && cd_nonzero)
                begin
                    cd_run_next = 1'b1;
                end
            end
            REQ_TOGGLE:
            begin
                if (mode_reg == MODE_CNTDN)
                begin
                    if (cd_nonzero || cd_run_reg)
                    begin
                        cd_run_next = !cd_run_reg;
                    end
                end
                else if (mode_reg == MODE_ALM)
                begin
                    al_armed_next = !al_armed_reg;
                end
            end
            REQ_POT:
            begin
                if (mode_reg == MODE_ALM)
                begin
                    al_hour_next = pot_sum[12:8];
                end
            end
            default:
            begin
            end
        endcase

        buzzer_next = (ring_next != 4'd0);
        if (cd_run_next && (cd_min_next == 6'd0) && (cd_sec_next inside {[6'd1:6'd9]}))
        begin
            digit_next = cd_sec_next[3:0];
        end
        else
        begin
            digit_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // payload of the input stage
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_t'(req_type);
            pot_reg <= pot_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_len_reg <= RING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ring_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_TOD;
            tod_hour_reg  <= TOD_HOURS_RESET;
            tod_min_reg   <= 6'd0;
            tod_sec_reg   <= 6'd0;
            al_hour_reg   <= 5'd0;
            al_min_reg    <= 6'd0;
            al_armed_reg  <= 1'b1;
            cd_min_reg    <= 6'd0;
            cd_sec_reg    <= 6'd0;
            cd_run_reg    <= 1'b0;
            ring_reg      <= 4'd0;
            buzzer_reg    <= 1'b0;
            digit_reg     <= 4'd0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                tod_hour_reg  <= tod_hour_next;
                tod_min_reg   <= tod_min_next;
                tod_sec_reg   <= tod_sec_next;
                al_hour_reg   <= al_hour_next;
                al_min_reg    <= al_min_next;
                al_armed_reg  <= al_armed_next;
                cd_min_reg    <= cd_min_next;
                cd_sec_reg    <= cd_sec_next;
                cd_run_reg    <= cd_run_next;
                ring_reg      <= ring_next;
                buzzer_reg    <= buzzer_next;
                digit_reg     <= digit_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // State only moves when an item is taken into the result stage, so the
    // state registers double as the held result.
    assign out_valid         = out_valid_reg;
    assign mode              = mode_reg;
    assign clock_hours       = tod_hour_reg;
    assign clock_minutes     = tod_min_reg;
    assign clock_seconds     = tod_sec_reg;
    assign countdown_minutes = cd_min_reg;
    assign countdown_seconds = cd_sec_reg;
    assign countdown_running = cd_run_reg;
    assign alarm_enabled     = al_armed_reg;
    assign alarm_hours       = al_hour_reg;
    assign alarm_minutes     = al_min_reg;
    assign buzzer_on         = buzzer_reg;
    assign countdown_digit   = digit_reg;

    assign tod_ok     = (tod_sec_reg <= MINSEC_MAX) && (tod_min_reg <= MINSEC_MAX) &&
                        (tod_hour_reg <= HOUR_MAX);
    assign alarm_ok   = (al_hour_reg <= HOUR_MAX) && (al_min_reg <= MINSEC_MAX);
    assign digit_ok   = cd_run_reg && (cd_min_reg == 6'd0) && (digit_reg == cd_sec_reg[3:0]);
    assign held_state = {mode_reg, tod_sec_reg, cd_sec_reg, ring_reg};

    `ASSERT_CLK(a_tod_range, tod_ok, "time of day out of range")
    `ASSERT_CLK(a_alarm_range, alarm_ok, "alarm setting out of range")
    `ASSERT_IMPL(a_digit_ctx, digit_reg != 4'd0, digit_ok, "digit shown outside final seconds")
    `ASSERT_NEXT(a_state_hold, !adv, $stable(held_state), "state moved without an item")
    `ASSERT_CLK(a_buzz_match, buzzer_reg == (ring_reg != 4'd0), "buzzer out of step with ring")

endmodule
